[rtl/sbit_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sbit_pkg;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_IDX_WIDTH   = 2;
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_BOX_LEFT   = 2'd0,
    REG_BOX_BOTTOM = 2'd1,
    REG_BOX_RIGHT  = 2'd2,
    REG_BOX_TOP    = 2'd3
  } cfg_reg_t;
endpackage
`default_nettype wire

[rtl/segment_box_intersect_test_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Ports                                   Transfer
// in       in   in_start_x/y, in_end_x/y                in_valid & in_ready
// out      out  out_hit                                 out_valid & out_ready
// cfg      in   cfg_index, cfg_data (box registers)     cfg_valid & cfg_ready
//
// One segment accepted per cycle while the output is empty or taken.
// Pipeline: bounds/differences, eight products, corner sides, verdict.
// Whole pipeline advances when the output stage is empty or taken; a stall
// freezes every stage. Synchronous active-low reset clears valids and box
// registers to zero. Config is always ready; unknown indices are ignored.
module segment_box_intersect_test_unit #(
  parameter int COORD_WIDTH = sbit_pkg::COORD_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire signed [COORD_WIDTH-1:0]           in_start_x,
  input  wire signed [COORD_WIDTH-1:0]           in_start_y,
  input  wire signed [COORD_WIDTH-1:0]           in_end_x,
  input  wire signed [COORD_WIDTH-1:0]           in_end_y,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic                                   out_hit,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [sbit_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  wire signed [COORD_WIDTH-1:0]           cfg_data
);
  logic signed [COORD_WIDTH-1:0] box_left_r, box_bottom_r, box_right_r, box_top_r;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r   <= '0;
      box_bottom_r <= '0;
      box_right_r  <= '0;
      box_top_r    <= '0;
    end else if (cfg_valid) begin
      unique case (sbit_pkg::cfg_reg_t'(cfg_index))
        sbit_pkg::REG_BOX_LEFT:   box_left_r   <= cfg_data;
        sbit_pkg::REG_BOX_BOTTOM: box_bottom_r <= cfg_data;
        sbit_pkg::REG_BOX_RIGHT:  box_right_r  <= cfg_data;
        sbit_pkg::REG_BOX_TOP:    box_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  sbit_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_v    (in_valid),
    .sx      (in_start_x),
    .sy      (in_start_y),
    .ex      (in_end_x),
    .ey      (in_end_y),
    .xl      (box_left_r),
    .yb      (box_bottom_r),
    .xr      (box_right_r),
    .yt      (box_top_r),
    .out_v   (out_valid),
    .out_hit (out_hit)
  );
endmodule
`default_nettype wire

[rtl/sbit_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// Four-stage datapath: differences, products, corner signs, verdict.
module sbit_pipe #(
  parameter int COORD_WIDTH = sbit_pkg::COORD_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           adv,
  input  wire                           in_v,
  input  wire signed [COORD_WIDTH-1:0]  sx,
  input  wire signed [COORD_WIDTH-1:0]  sy,
  input  wire signed [COORD_WIDTH-1:0]  ex,
  input  wire signed [COORD_WIDTH-1:0]  ey,
  input  wire signed [COORD_WIDTH-1:0]  xl,
  input  wire signed [COORD_WIDTH-1:0]  yb,
  input  wire signed [COORD_WIDTH-1:0]  xr,
  input  wire signed [COORD_WIDTH-1:0]  yt,
  output logic                          out_v,
  output logic                          out_hit
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  // stage 1
  logic                 v1_r, ok1_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [DW-1:0] cxl_r, cxr_r, cyb_r, cyt_r;
  // stage 2
  logic                 v2_r, ok2_r;
  logic signed [PW-1:0] pa_r [4];
  logic signed [PW-1:0] pb_r [4];
  // stage 3
  logic                 v3_r, ok3_r;
  logic [3:0]           pos_r, neg_r;
  // stage 4
  logic                 v4_r, hit4_r;

  logic                 ok1_nxt;
  logic signed [DW-1:0] cxs [4];
  logic signed [DW-1:0] cys [4];
  logic signed [CW-1:0] cr [4];

  always_comb begin
    logic signed [COORD_WIDTH-1:0] lox, hix, loy, hiy;
    lox = (sx < ex) ? sx : ex;
    hix = (sx < ex) ? ex : sx;
    loy = (sy < ey) ? sy : ey;
    hiy = (sy < ey) ? ey : sy;
    ok1_nxt = !(xl > xr) && !(yb > yt) && !(hix < xl) && !(lox > xr)
              && !(hiy < yb) && !(loy > yt);
  end

  assign cxs[0] = cxl_r; assign cys[0] = cyb_r;
  assign cxs[1] = cxr_r; assign cys[1] = cyb_r;
  assign cxs[2] = cxr_r; assign cys[2] = cyt_r;
  assign cxs[3] = cxl_r; assign cys[3] = cyt_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cr[i] = CW'(pa_r[i]) - CW'(pb_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_r <= ok1_nxt;
      dx_r  <= DW'(ex) - DW'(sx);
      dy_r  <= DW'(ey) - DW'(sy);
      cxl_r <= DW'(xl) - DW'(sx);
      cxr_r <= DW'(xr) - DW'(sx);
      cyb_r <= DW'(yb) - DW'(sy);
      cyt_r <= DW'(yt) - DW'(sy);
      ok2_r <= ok1_r;
      for (int i = 0; i < 4; i++) begin
        pa_r[i] <= PW'(dx_r) * PW'(cys[i]);
        pb_r[i] <= PW'(dy_r) * PW'(cxs[i]);
      end
      ok3_r <= ok2_r;
      for (int i = 0; i < 4; i++) begin
        neg_r[i] <= cr[i][CW-1];
        pos_r[i] <= !cr[i][CW-1] && (cr[i] != '0);
      end
      hit4_r <= ok3_r && !(&pos_r) && !(&neg_r);
    end
  end

  assign out_v   = v4_r;
  assign out_hit = hit4_r;
endmodule
`default_nettype wire

[tb/segment_box_intersect_test_unit_tb.sv]
`timescale 1ns / 1ps

// Hit-verdict scoreboard: holds the current box, predicts each segment's
// verdict on transfer in, and checks verdicts in order on transfer out.
class hit_scoreboard;
  logic signed [15:0] left, bottom, right, top;
  bit expected_hits[$];
  int errors;
  int segs, hits_seen;

  function void set_box(sbit_pkg::cfg_reg_t idx, logic signed [15:0] v);
    case (idx)
      sbit_pkg::REG_BOX_LEFT:   left   = v;
      sbit_pkg::REG_BOX_BOTTOM: bottom = v;
      sbit_pkg::REG_BOX_RIGHT:  right  = v;
      sbit_pkg::REG_BOX_TOP:    top    = v;
      default: ;
    endcase
  endfunction

  // Separating-axis test with exact 64-bit cross products.
  function bit meets_box(longint sx, longint sy, longint ex, longint ey);
    longint lox, hix, loy, hiy, dx, dy, s;
    longint kx[4], ky[4];
    int pos, neg;
    lox = (sx < ex) ? sx : ex;  hix = (sx < ex) ? ex : sx;
    loy = (sy < ey) ? sy : ey;  hiy = (sy < ey) ? ey : sy;
    if (left > right || bottom > top) return 0;
    if (hix < left || lox > right || hiy < bottom || loy > top) return 0;
    dx = ex - sx;  dy = ey - sy;
    kx[0] = left;  ky[0] = bottom;
    kx[1] = right; ky[1] = bottom;
    kx[2] = right; ky[2] = top;
    kx[3] = left;  ky[3] = top;
    pos = 0; neg = 0;
    for (int i = 0; i < 4; i++) begin
      s = dx * (ky[i] - sy) - dy * (kx[i] - sx);
      if (s > 0) pos++;
      else if (s < 0) neg++;
    end
    return !(pos == 4 || neg == 4);
  endfunction

  function void note_segment(logic signed [15:0] sx, sy, ex, ey);
    expected_hits.push_back(meets_box(sx, sy, ex, ey));
    segs++;
  endfunction

  function bit check_hit(bit got, output bit want, output bit orphan);
    orphan = (expected_hits.size() == 0);
    want = 0;
    if (orphan) return 0;
    want = expected_hits.pop_front();
    hits_seen += got;
    return got == want;
  endfunction
endclass

module segment_box_intersect_test_unit_tb;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic signed [15:0] in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic signed [15:0] cfg_data = 0;
  logic [sbit_pkg::CFG_IDX_WIDTH-1:0] cfg_index = 0;
  logic in_ready, out_valid, out_hit, cfg_ready;

  hit_scoreboard board;
  int mismatches = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls

  always #5 clk = ~clk;

  segment_box_intersect_test_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_start_x, .in_start_y,
    .in_end_x, .in_end_y, .out_valid, .out_ready, .out_hit,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Receiver: random back-pressure, checking each transfer on the same edge.
  always @(posedge clk) begin
    bit want, orphan;
    if (rst_n && out_valid && out_ready) begin
      if (!board.check_hit(out_hit, want, orphan)) begin
        if (orphan) report("verdict with no segment outstanding");
        else report($sformatf("hit %0b, expected %0b", out_hit, want));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One register write; config is idle-only so the box is stable for predictions.
  // Valid is left up so writes can follow back to back; set_box drops it.
  task automatic write_box(sbit_pkg::cfg_reg_t idx, logic signed [15:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_box(idx, v);
  endtask

  task automatic set_box(int l, int b, int r, int t);
    write_box(sbit_pkg::REG_BOX_LEFT, 16'(l));
    write_box(sbit_pkg::REG_BOX_BOTTOM, 16'(b));
    write_box(sbit_pkg::REG_BOX_RIGHT, 16'(r));
    write_box(sbit_pkg::REG_BOX_TOP, 16'(t));
    cfg_valid <= 0;
  endtask

  // Offers one segment; valid stays up until the transfer, then drops only
  // if the next segment is not sent straight after.
  task automatic send_segment(int sx, int sy, int ex, int ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_start_x <= 16'(sx); in_start_y <= 16'(sy);
    in_end_x <= 16'(ex); in_end_y <= 16'(ey);
    do @(posedge clk); while (!in_ready);
    board.note_segment(16'(sx), 16'(sy), 16'(ex), 16'(ey));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.expected_hits.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Near the box half of the time, so all outcomes are exercised.
  function automatic int coord(int lo, int hi);
    int c;
    case ($urandom_range(3))
      0: c = $urandom_range(65535) - 32768;
      1: c = $urandom_range(1) ? 32767 : -32768;
      default: begin
        c = lo - 8 + $urandom_range(((hi - lo) < 0 ? 0 : hi - lo) + 16);
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
      end
    endcase
    return c;
  endfunction

  task automatic random_segments(int n, int l, int b, int r, int t);
    int sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = coord(l, r); sy = coord(b, t);
      if ($urandom_range(9) == 0) send_segment(sx, sy, sx, sy);
      else send_segment(sx, sy, coord(l, r), coord(b, t));
    end
  endtask

  initial begin
    int l, b, r, t;
    board = new();
    board.set_box(sbit_pkg::REG_BOX_LEFT, 16'sd0);
    board.set_box(sbit_pkg::REG_BOX_BOTTOM, 16'sd0);
    board.set_box(sbit_pkg::REG_BOX_RIGHT, 16'sd0);
    board.set_box(sbit_pkg::REG_BOX_TOP, 16'sd0);
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset box is the single point at the origin.
    send_segment(0, 0, 0, 0);
    send_segment(-5, 5, 5, -5);
    send_segment(1, 1, 1, 1);
    drain();

    set_box(-10, -10, 10, 10);
    send_segment(0, 0, 0, 0);              // point inside
    send_segment(11, 0, 11, 0);            // point outside
    send_segment(-20, 0, 20, 0);           // straight through
    send_segment(-20, 10, 20, 10);         // along top edge
    send_segment(0, 20, 20, 0);            // grazes corner (10,10)
    send_segment(0, 21, 21, 0);            // just misses corner
    send_segment(-20, 11, 20, 11);         // both above
    send_segment(-20, -5, -11, 30);        // passes left, x bounds apart
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 32767, -32768, 32767);
    drain();

    set_box(-32768, -32768, 32767, 32767); // whole plane
    send_segment(32767, 32767, -32768, -32768);
    send_segment(-1, -1, -1, -1);
    drain();

    set_box(5, -5, -5, 5);                 // inverted in x
    send_segment(0, 0, 0, 0);
    send_segment(-32768, 0, 32767, 0);
    drain();
    set_box(-5, 5, 5, -5);                 // inverted in y
    send_segment(0, 0, 0, 0);
    drain();

    // Random boxes, each under one idling phase.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      l = $urandom_range(65535) - 32768;
      if (ph == 7 && l == -32768) l = -32767;
      b = $urandom_range(65535) - 32768;
      r = (ph == 7) ? l - 1 : l + $urandom_range(ph < 4 ? 200 : 65535);
      t = b + $urandom_range(ph < 4 ? 200 : 65535);
      if (r > 32767) r = 32767;
      if (t > 32767) t = 32767;
      set_box(l, b, r, t);
      random_segments(50, l, b, r, t);
      drain();
    end

    $display("%0d segments tested against 13 boxes (incl. inverted, full-range), %0d hits",
             board.segs, board.hits_seen);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
